/* design/dds_pkg.sv */
// Shared types, constants and the raw waveform function of the DDS generator.
// No dependencies; dds_sample_if and dds_waveform_generator import it.
`timescale 1ns / 1ps

package dds_pkg;

  localparam int PHASE_W   = 32;
  localparam int SAMPLE_W  = 32;
  localparam int CODE_W    = 16;
  localparam int RAW_W     = 18;                    // raw Q16.16 lies in -1..+1
  localparam int PROD_W    = SAMPLE_W + RAW_W;      // shared multiplier result
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [PHASE_W-1:0]      HALF_TURN = 32'h8000_0000;
  localparam logic signed [RAW_W-1:0] ONE_Q16   = 18'sd65536;
  localparam logic [CODE_W-1:0]       CODE_MAX  = 16'hFFFF;

  // waveform selector codes
  localparam logic [1:0] WAVE_TRIANGLE = 2'd0;
  localparam logic [1:0] WAVE_SAWTOOTH = 2'd1;
  localparam logic [1:0] WAVE_SQUARE   = 2'd2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WAVE_SELECT     = 3'd0,
    REG_PHASE_INCREMENT = 3'd1,
    REG_GAIN            = 3'd2,
    REG_DC_OFFSET       = 3'd3,
    REG_DUTY_THRESHOLD  = 3'd4,
    REG_ZERO_CODE       = 3'd5,
    REG_CODE_SCALE      = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_OFFSET,
    ST_SPAN,
    ST_CODE
  } state_t;

  // Raw Q16.16 waveform value for one phase.
  function automatic logic signed [RAW_W-1:0] raw_wave(
    input logic [1:0]         wave_sel,
    input logic [PHASE_W-1:0] phase,
    input logic [15:0]        duty
  );
    logic signed [RAW_W-1:0] r;
    begin
      unique case (wave_sel)
        WAVE_TRIANGLE: begin
          if (phase < HALF_TURN) begin
            r = $signed({1'b0, phase[30:14]}) - ONE_Q16;
          end else begin
            r = ONE_Q16 - $signed({1'b0, phase[30:14]});
          end
        end
        WAVE_SAWTOOTH: r = $signed({1'b0, phase[31:15]}) - ONE_Q16;
        WAVE_SQUARE:   r = (phase[31:16] < duty) ? ONE_Q16 : -ONE_Q16;
        default:       r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

/* design/dds_tick_if.sv */
// Request channel of the DDS generator: valid, ready and the tick field.
// No dependencies.
`timescale 1ns / 1ps

interface dds_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

/* design/dds_sample_if.sv */
// Result channel of the DDS generator: valid, ready, sample and DAC code.
// Depends on dds_pkg for the field widths.
`timescale 1ns / 1ps

interface dds_sample_if;
  import dds_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [CODE_W-1:0]          dac_code;

  modport source (output valid, output sample_value, output dac_code, input ready);
  modport sink   (input valid, input sample_value, input dac_code, output ready);
endinterface

/* design/dds_waveform_generator.sv */
// Top level of the DDS waveform generator: phase accumulator, sequencer and
// one shared multiplier. Depends on dds_pkg, dds_tick_if and dds_sample_if.
`timescale 1ns / 1ps

//  channel   | dir | fields                       | handshake
//  ----------+-----+------------------------------+-----------------------
//  ticks     | in  | tick                         | valid/ready
//  samples   | out | sample_value, dac_code       | valid/ready
//  cfg       | in  | cfg_index, cfg_data          | cfg_we, always taken
//
//  One item at a time: accept in idle, then gain multiply, offset add,
//  span multiply and code saturate (ticks.ready low for these four); both
//  multiplies share one 32x18 signed multiplier. The output register takes the
//  result at the code step. A tick-low item is taken in idle, no sample.
//  A result still held at the code step makes the sequencer wait there.
//  rst (synchronous) resets state, config registers, out_valid and the phase; no memory.

module dds_waveform_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dds_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [dds_pkg::CFG_W-1:0]      cfg_data,
  dds_tick_if.sink                       ticks,
  dds_sample_if.source                   samples
);
  import dds_pkg::*;

  // configuration registers
  logic [1:0]                wave_select;
  logic [PHASE_W-1:0]        phase_increment;
  logic signed [SAMPLE_W-1:0] gain;
  logic [SAMPLE_W-1:0]       dc_offset;
  logic [15:0]               duty_threshold;
  logic [CODE_W-1:0]         zero_code;
  logic [CODE_W-1:0]         code_scale;

  // state and datapath
  state_t                    state, state_next;
  logic [PHASE_W-1:0]        phase_acc;
  logic signed [RAW_W-1:0]   raw_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  // output register
  logic                      out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [CODE_W-1:0]         out_code;

  // sequencer outputs
  logic                      accept;
  logic                      take_tick;
  logic                      load_prod;
  logic                      load_sample;
  logic                      load_out;
  logic                      out_free;

  // shared multiplier
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [RAW_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   mul_p;

  logic signed [CODE_W+18:0]  code_sum;
  logic [CODE_W-1:0]          code_sat;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select     <= WAVE_TRIANGLE;
      phase_increment <= '0;
      gain            <= 32'sd65536;
      dc_offset       <= '0;
      duty_threshold  <= 16'd32768;
      zero_code       <= 16'd32768;
      code_scale      <= 16'd32768;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_WAVE_SELECT:     wave_select     <= cfg_data[1:0];
        REG_PHASE_INCREMENT: phase_increment <= cfg_data;
        REG_GAIN:            gain            <= $signed(cfg_data);
        REG_DC_OFFSET:       dc_offset       <= cfg_data;
        REG_DUTY_THRESHOLD:  duty_threshold  <= cfg_data[15:0];
        REG_ZERO_CODE:       zero_code       <= cfg_data[15:0];
        REG_CODE_SCALE:      code_scale      <= cfg_data[15:0];
        default: ;                              // unknown index: dropped
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign out_free      = !out_valid || samples.ready;
  assign ticks.ready   = (state == ST_IDLE);
  assign accept        = ticks.valid && ticks.ready;
  assign take_tick     = accept && ticks.tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    load_prod   = 1'b0;
    load_sample = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (take_tick) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        load_prod  = 1'b1;
        state_next = ST_OFFSET;
      end
      ST_OFFSET: begin
        load_sample = 1'b1;
        state_next  = ST_SPAN;
      end
      ST_SPAN: begin
        load_prod  = 1'b1;
        state_next = ST_CODE;
      end
      ST_CODE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  // gain step: raw * gain; span step: sample * span (span is unsigned)
  assign mul_a = (state == ST_SCALE) ? gain : sample_q;
  assign mul_b = (state == ST_SCALE) ? raw_q : $signed({2'b00, code_scale});
  assign mul_p = mul_a * mul_b;

  // floor(prod / 2^16) + centre, wide, then clamp to 0..65535
  assign code_sum = $signed({prod_q[PROD_W-1], prod_q[PROD_W-1:16]})
                  + $signed({19'd0, zero_code});

  always_comb begin
    if (code_sum[CODE_W+18]) begin
      code_sat = '0;
    end else if (|code_sum[CODE_W+17:CODE_W]) begin
      code_sat = CODE_MAX;
    end else begin
      code_sat = code_sum[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (take_tick) begin
      phase_acc <= phase_acc + phase_increment;
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      raw_q <= raw_wave(wave_select, phase_acc, duty_threshold);
    end
    if (load_prod) begin
      prod_q <= mul_p;
    end
    if (load_sample) begin
      // bits 47:16 are floor(raw*gain / 2^16) wrapped to 32 bits
      sample_q <= $signed(prod_q[47:16] + dc_offset);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (samples.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample <= sample_q;
      out_code   <= code_sat;
    end
  end

  assign samples.valid        = out_valid;
  assign samples.sample_value = out_sample;
  assign samples.dac_code     = out_code;

`ifndef SYNTHESIS
  // a tick starts the sequence and advances the phase by the step
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    take_tick |=> (state == ST_SCALE) &&
                  (phase_acc == 32'($past(phase_acc) + $past(phase_increment))))
    else $error("tick did not start the sequence or advance the phase");

  // an item with tick low leaves the phase alone and starts nothing
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && !ticks.tick) |=> $stable(phase_acc) && (state == ST_IDLE))
    else $error("tick-low item changed state");

  // a finished result waits while the output register is still held
  a_code_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CODE && !out_free) |=> (state == ST_CODE) && out_valid)
    else $error("result lost while output register was full");
`endif

endmodule
